// ===== hw/rtl/gso_pkg.sv =====
// ----------------------------------------------------------------------------
// gso_pkg
// Shared widths, register indexes and arithmetic helpers for the
// Gram-Schmidt orthonormaliser.
// ----------------------------------------------------------------------------
package gso_pkg;

    localparam int SAMPLE_W   = 32;   // Q16.16 input element
    localparam int VALUE_W    = 32;   // Q2.30 output element
    localparam int WORK_W     = 48;   // working vector element
    localparam int ALIGN_BITS = 26;   // magnitudes aligned to this bit length
    localparam int FRAC_BITS  = 30;
    localparam int LEN_W      = 6;    // bit length of a work magnitude, 0..48
    localparam int NRM_W      = 32;
    localparam int QUO_W      = 31;
    localparam int DVD_W      = ALIGN_BITS + FRAC_BITS + 1;
    localparam int OP_W       = 34;   // shared multiplier operand
    localparam int PROD_W     = 2 * OP_W;
    localparam int ACC_W      = 64;
    localparam int RND_W      = 36;
    localparam int OVL_W      = 33;
    localparam int TDATA_W    = 48;   // value, vector index, element index, padded

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_LEN_W  = 7;
    localparam int CFG_CNT_W  = 5;

    localparam logic [CFG_ADDR_W-1:0] REG_VECTOR_LENGTH = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_VECTOR_COUNT  = 1'b1;

    function automatic logic [WORK_W-1:0] mag_w(input logic signed [WORK_W-1:0] x);
        return x[WORK_W-1] ? WORK_W'(-x) : WORK_W'(x);
    endfunction

    // scale a magnitude of bit length len to ALIGN_BITS bits, truncating
    function automatic logic [ALIGN_BITS-1:0] align_mag(input logic [WORK_W-1:0] mag,
                                                       input logic [LEN_W-1:0]  len);
        logic [WORK_W-1:0] sh;
        if (len > LEN_W'(ALIGN_BITS)) begin
            sh = mag >> (len - LEN_W'(ALIGN_BITS));
        end else begin
            sh = mag << (LEN_W'(ALIGN_BITS) - len);
        end
        return sh[ALIGN_BITS-1:0];
    endfunction

    // x / 2^30, rounded half away from zero
    function automatic logic signed [RND_W-1:0] round_q30(input logic signed [ACC_W-1:0] x);
        logic [ACC_W-1:0] mag;
        logic [ACC_W:0]   sum;
        logic [RND_W-1:0] m;
        mag = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
        sum = {1'b0, mag} + (65'd1 << (FRAC_BITS - 1));
        m   = {1'b0, sum[ACC_W:FRAC_BITS]};
        return x[ACC_W-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W-1:0] s;
        s = a + b;
        if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
            return a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s;
    endfunction

endpackage

// ===== hw/rtl/gso_ram.sv =====
// ----------------------------------------------------------------------------
// gso_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gso_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/gram_schmidt_orthonormalizer_core.sv =====
// ----------------------------------------------------------------------------
// gram_schmidt_orthonormalizer_core
// Elements stream in vector after vector as Q16.16; when a vector is complete
// it is normalised, then for each earlier vector of the set (ascending) the
// projection is removed and the result renormalised REPEATS times. The vector
// then leaves as n Q2.30 beats and is kept as a basis vector. The block is
// not ready while a vector is worked on. All arithmetic runs through one
// 34x34 multiplier, one square-root step unit and one radix-2 divider under
// a small sequencer. The work for a vector is dominated by the divide per
// element of every normalisation; elements of an unfinished vector are
// taken one per cycle. A zero norm leaves the vector at zero and sets tuser
// on every beat of that vector.
// ----------------------------------------------------------------------------
module gram_schmidt_orthonormalizer_core #(
    parameter int MAX_LENGTH  = 64,
    parameter int MAX_VECTORS = 16,
    parameter int REPEATS     = 2
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [gso_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [gso_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gso_pkg::SAMPLE_W-1:0]     s_tdata,   // [31:0] sample
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] value, [35:32] vector_index, [41:36] element_index, rest zero
    output logic [gso_pkg::TDATA_W-1:0]      m_tdata,
    output logic                             m_tlast,
    output logic                             m_tuser    // degenerate
);
    import gso_pkg::*;

    localparam int EC_W      = $clog2(MAX_LENGTH);
    localparam int VC_W      = $clog2(MAX_VECTORS);
    localparam int BA_W      = $clog2(MAX_LENGTH * MAX_VECTORS);
    localparam int RP_W      = (REPEATS > 1) ? $clog2(REPEATS) : 1;
    localparam int LEN_CMP_W = (EC_W + 1 > CFG_LEN_W) ? EC_W + 1 : CFG_LEN_W;
    localparam int CNT_CMP_W = (VC_W + 1 > CFG_CNT_W) ? VC_W + 1 : CFG_CNT_W;
    localparam int VI_X_W    = (VC_W > 4) ? VC_W : 4;
    localparam int EI_X_W    = (EC_W > 6) ? EC_W : 6;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_OR        = 4'd1;
    localparam logic [3:0] S_LEN       = 4'd2;
    localparam logic [3:0] S_SUM       = 4'd3;
    localparam logic [3:0] S_SQRT      = 4'd4;
    localparam logic [3:0] S_DIV_RD    = 4'd5;
    localparam logic [3:0] S_DIV_LD    = 4'd6;
    localparam logic [3:0] S_DIV_IT    = 4'd7;
    localparam logic [3:0] S_DIV_WR    = 4'd8;
    localparam logic [3:0] S_NEXT      = 4'd9;
    localparam logic [3:0] S_DOT       = 4'd10;
    localparam logic [3:0] S_OVL       = 4'd11;
    localparam logic [3:0] S_UPD       = 4'd12;
    localparam logic [3:0] S_EMIT_RD   = 4'd13;
    localparam logic [3:0] S_EMIT_LD   = 4'd14;
    localparam logic [3:0] S_EMIT_WAIT = 4'd15;

    logic [3:0]             state_reg;
    logic [CFG_LEN_W-1:0]   vlen_reg;
    logic [CFG_CNT_W-1:0]   vcnt_reg;
    logic [EC_W-1:0]        elem_cnt_reg;
    logic [VC_W-1:0]        vec_cnt_reg;
    logic [BA_W-1:0]        vbase_reg;
    logic [EC_W-1:0]        last_idx_reg;
    logic [VC_W-1:0]        vi_reg;
    logic [VC_W-1:0]        j_reg;
    logic [RP_W-1:0]        r_reg;
    logic [BA_W-1:0]        jbase_reg;
    logic                   degen_reg;
    logic [EC_W-1:0]        idx_reg;
    logic                   issue_reg;

    // element pipeline: RAM read, operands, product, round
    logic                   v1_reg, v2_reg, v3_reg, v4_reg;
    logic [EC_W-1:0]        idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic signed [OP_W-1:0] opa_reg, opb_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [WORK_W-1:0] wb_reg, wc_reg, wd_reg;
    logic signed [RND_W-1:0]  rnd_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic [WORK_W-1:0]      or_acc_reg;
    logic [WORK_W-1:0]      lz_reg;
    logic [LEN_W-1:0]       bitlen_reg;
    logic [ACC_W-1:0]       sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [NRM_W-1:0]       nrm_reg;
    logic                   neg_reg;
    logic [NRM_W-1:0]       rem_reg;
    logic [QUO_W-1:0]       dvd_reg, quo_reg;
    logic [4:0]             div_cnt_reg;
    logic signed [OVL_W-1:0] ovl_reg;

    logic [VALUE_W-1:0]     m_value_reg;
    logic [3:0]             m_vi_reg;
    logic [5:0]             m_ei_reg;
    logic                   m_last_reg, m_degen_reg, m_valid_reg;

    // RAM ports
    logic                     w_wr_en;
    logic [EC_W-1:0]          w_wr_addr;
    logic signed [WORK_W-1:0] w_wr_data, w_rd_data;
    logic                     b_wr_en;
    logic [BA_W-1:0]          b_wr_addr, b_rd_addr;
    logic [VALUE_W-1:0]       b_wr_data, b_rd_data;

    logic [LEN_CMP_W-1:0]   len_eff;
    logic [CNT_CMP_W-1:0]   cnt_eff;
    logic                   s_acc;
    logic                   pipe_busy;
    logic [WORK_W-1:0]      rd_mag;
    logic [ALIGN_BITS-1:0]  rd_b;
    logic [ACC_W:0]         sq_t;
    logic [ACC_W-1:0]       sq_res_next;
    logic                   sq_ge;
    logic [DVD_W-1:0]       dvd_full;
    logic [NRM_W:0]         div_t;
    logic                   div_ge;
    logic [QUO_W-1:0]       quo_clamp;
    logic [WORK_W-1:0]      div_q;
    logic signed [WORK_W-1:0] div_w, upd_w;
    logic signed [RND_W-1:0]  ovl_rnd;
    logic [VALUE_W-1:0]     rd_sat;
    logic [VI_X_W-1:0]      vi_x;
    logic [EI_X_W-1:0]      ei_x;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_ei_reg, m_vi_reg, m_value_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_degen_reg;

    always_comb begin
        if (vlen_reg == '0) begin
            len_eff = LEN_CMP_W'(1);
        end else if (LEN_CMP_W'(vlen_reg) > LEN_CMP_W'(MAX_LENGTH)) begin
            len_eff = LEN_CMP_W'(MAX_LENGTH);
        end else begin
            len_eff = LEN_CMP_W'(vlen_reg);
        end
        if (vcnt_reg == '0) begin
            cnt_eff = CNT_CMP_W'(1);
        end else if (CNT_CMP_W'(vcnt_reg) > CNT_CMP_W'(MAX_VECTORS)) begin
            cnt_eff = CNT_CMP_W'(MAX_VECTORS);
        end else begin
            cnt_eff = CNT_CMP_W'(vcnt_reg);
        end
    end

    assign pipe_busy = issue_reg || v1_reg || v2_reg || v3_reg || v4_reg;
    assign rd_mag    = mag_w(w_rd_data);
    assign rd_b      = align_mag(rd_mag, bitlen_reg);

    // one square-root step
    assign sq_t  = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
    assign sq_ge = ({1'b0, sq_v_reg} >= sq_t);
    assign sq_res_next = sq_ge ? ((sq_res_reg >> 1) + sq_bit_reg) : (sq_res_reg >> 1);

    // one restoring divide step
    assign dvd_full  = {1'b0, rd_b, {FRAC_BITS{1'b0}}} + DVD_W'(nrm_reg >> 1);
    assign div_t     = {rem_reg, dvd_reg[QUO_W-1]};
    assign div_ge    = (div_t >= {1'b0, nrm_reg});
    assign quo_clamp = (quo_reg > QUO_W'(1 << FRAC_BITS)) ? QUO_W'(1 << FRAC_BITS) : quo_reg;
    assign div_q     = WORK_W'(quo_clamp);
    assign div_w     = neg_reg ? -$signed(div_q) : $signed(div_q);

    assign upd_w   = wd_reg - {{(WORK_W-RND_W){rnd_reg[RND_W-1]}}, rnd_reg};
    assign ovl_rnd = round_q30(acc_reg);

    always_comb begin
        if (w_rd_data > 48'sd2147483647) begin
            rd_sat = 32'h7FFF_FFFF;
        end else if (w_rd_data < -48'sd2147483648) begin
            rd_sat = 32'h8000_0000;
        end else begin
            rd_sat = w_rd_data[VALUE_W-1:0];
        end
    end

    assign vi_x = VI_X_W'(vi_reg);
    assign ei_x = EI_X_W'(idx_reg);

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = idx4_reg;
        w_wr_data = upd_w;
        case (state_reg)
            S_IDLE: begin
                w_wr_en   = s_acc;
                w_wr_addr = elem_cnt_reg;
                w_wr_data = {{(WORK_W-SAMPLE_W){s_tdata[SAMPLE_W-1]}}, s_tdata};
            end
            S_DIV_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = idx_reg;
                w_wr_data = div_w;
            end
            S_UPD: begin
                w_wr_en = v4_reg;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    assign b_wr_en   = (state_reg == S_EMIT_LD);
    assign b_wr_addr = vbase_reg + BA_W'(idx_reg);
    assign b_wr_data = rd_sat;
    assign b_rd_addr = jbase_reg + BA_W'(idx_reg);

    gso_ram #(.WIDTH(WORK_W), .DEPTH(MAX_LENGTH)) u_work_ram (
        .aclk    (aclk),
        .wr_en   (w_wr_en),
        .wr_addr (w_wr_addr),
        .wr_data (w_wr_data),
        .rd_addr (idx_reg),
        .rd_data (w_rd_data)
    );

    gso_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_LENGTH * MAX_VECTORS)) u_basis_ram (
        .aclk    (aclk),
        .wr_en   (b_wr_en),
        .wr_addr (b_wr_addr),
        .wr_data (b_wr_data),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    // datapath registers, no reset
    always_ff @(posedge aclk) begin
        idx1_reg <= idx_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;
        wb_reg   <= w_rd_data;
        wc_reg   <= wb_reg;
        wd_reg   <= wc_reg;
        case (state_reg)
            S_SUM: begin
                opa_reg <= OP_W'(rd_b);
                opb_reg <= OP_W'(rd_b);
            end
            S_DOT: begin
                opa_reg <= w_rd_data[OP_W-1:0];
                opb_reg <= {{(OP_W-VALUE_W){b_rd_data[VALUE_W-1]}}, b_rd_data};
            end
            default: begin
                opa_reg <= {ovl_reg[OVL_W-1], ovl_reg};
                opb_reg <= {{(OP_W-VALUE_W){b_rd_data[VALUE_W-1]}}, b_rd_data};
            end
        endcase
        prod_reg <= opa_reg * opb_reg;
        rnd_reg  <= round_q30(prod_reg[ACC_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            vlen_reg     <= CFG_LEN_W'(64);
            vcnt_reg     <= CFG_CNT_W'(16);
            elem_cnt_reg <= '0;
            vec_cnt_reg  <= '0;
            vbase_reg    <= '0;
            issue_reg    <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
            idx_reg      <= '0;
            j_reg        <= '0;
            r_reg        <= '0;
            degen_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_VECTOR_LENGTH: vlen_reg <= cfg_wdata[CFG_LEN_W-1:0];
                    REG_VECTOR_COUNT:  vcnt_reg <= cfg_wdata[CFG_CNT_W-1:0];
                    default: ;
                endcase
            end

            v1_reg <= issue_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (issue_reg) begin
                if (idx_reg == last_idx_reg) begin
                    issue_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (v1_reg && state_reg == S_OR) begin
                or_acc_reg <= or_acc_reg | rd_mag;
            end
            if (v3_reg && (state_reg == S_SUM || state_reg == S_DOT)) begin
                acc_reg <= sat_add(acc_reg, prod_reg[ACC_W-1:0]);
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        if (LEN_CMP_W'(elem_cnt_reg) + 1'b1 >= len_eff) begin
                            last_idx_reg <= elem_cnt_reg;
                            vi_reg       <= vec_cnt_reg;
                            j_reg        <= '0;
                            r_reg        <= '0;
                            jbase_reg    <= '0;
                            degen_reg    <= 1'b0;
                            or_acc_reg   <= '0;
                            issue_reg    <= 1'b1;
                            idx_reg      <= '0;
                            state_reg    <= S_OR;
                        end else begin
                            elem_cnt_reg <= elem_cnt_reg + 1'b1;
                        end
                    end
                end
                S_OR: begin
                    if (!pipe_busy) begin
                        if (or_acc_reg == '0) begin
                            degen_reg <= 1'b1;
                            state_reg <= S_NEXT;
                        end else begin
                            lz_reg     <= or_acc_reg;
                            bitlen_reg <= LEN_W'(WORK_W);
                            state_reg  <= S_LEN;
                        end
                    end
                end
                S_LEN: begin
                    // bit length of the OR of all magnitudes equals that of the largest
                    if (lz_reg[WORK_W-1]) begin
                        acc_reg   <= '0;
                        issue_reg <= 1'b1;
                        idx_reg   <= '0;
                        state_reg <= S_SUM;
                    end else begin
                        lz_reg     <= lz_reg << 1;
                        bitlen_reg <= bitlen_reg - 1'b1;
                    end
                end
                S_SUM: begin
                    if (!pipe_busy) begin
                        sq_v_reg   <= acc_reg;
                        sq_res_reg <= '0;
                        sq_bit_reg <= 64'h4000_0000_0000_0000;
                        state_reg  <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sq_ge) begin
                        sq_v_reg <= sq_v_reg - sq_t[ACC_W-1:0];
                    end
                    sq_res_reg <= sq_res_next;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg[0]) begin
                        nrm_reg   <= sq_res_next[NRM_W-1:0];
                        idx_reg   <= '0;
                        state_reg <= S_DIV_RD;
                    end
                end
                S_DIV_RD: begin
                    state_reg <= S_DIV_LD;
                end
                S_DIV_LD: begin
                    neg_reg     <= w_rd_data[WORK_W-1];
                    rem_reg     <= NRM_W'(dvd_full[DVD_W-1:QUO_W]);
                    dvd_reg     <= dvd_full[QUO_W-1:0];
                    quo_reg     <= '0;
                    div_cnt_reg <= '0;
                    state_reg   <= S_DIV_IT;
                end
                S_DIV_IT: begin
                    rem_reg     <= div_ge ? NRM_W'(div_t - {1'b0, nrm_reg}) : div_t[NRM_W-1:0];
                    quo_reg     <= {quo_reg[QUO_W-2:0], div_ge};
                    dvd_reg     <= dvd_reg << 1;
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == 5'(QUO_W - 1)) begin
                        state_reg <= S_DIV_WR;
                    end
                end
                S_DIV_WR: begin
                    if (idx_reg == last_idx_reg) begin
                        state_reg <= S_NEXT;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_DIV_RD;
                    end
                end
                S_NEXT: begin
                    idx_reg <= '0;
                    if (j_reg < vi_reg) begin
                        acc_reg   <= '0;
                        issue_reg <= 1'b1;
                        state_reg <= S_DOT;
                    end else begin
                        state_reg <= S_EMIT_RD;
                    end
                end
                S_DOT: begin
                    if (!pipe_busy) begin
                        state_reg <= S_OVL;
                    end
                end
                S_OVL: begin
                    if (ovl_rnd > 36'sd2147483648) begin
                        ovl_reg <= 33'sd2147483648;
                    end else if (ovl_rnd < -36'sd2147483648) begin
                        ovl_reg <= -33'sd2147483648;
                    end else begin
                        ovl_reg <= ovl_rnd[OVL_W-1:0];
                    end
                    issue_reg <= 1'b1;
                    idx_reg   <= '0;
                    state_reg <= S_UPD;
                end
                S_UPD: begin
                    if (!pipe_busy) begin
                        if (r_reg == RP_W'(REPEATS - 1)) begin
                            r_reg     <= '0;
                            j_reg     <= j_reg + 1'b1;
                            jbase_reg <= BA_W'(jbase_reg + MAX_LENGTH);
                        end else begin
                            r_reg <= r_reg + 1'b1;
                        end
                        or_acc_reg <= '0;
                        issue_reg  <= 1'b1;
                        idx_reg    <= '0;
                        state_reg  <= S_OR;
                    end
                end
                S_EMIT_RD: begin
                    state_reg <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    m_value_reg <= rd_sat;
                    m_vi_reg    <= vi_x[3:0];
                    m_ei_reg    <= ei_x[5:0];
                    m_last_reg  <= (idx_reg == last_idx_reg);
                    m_degen_reg <= degen_reg;
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_EMIT_WAIT;
                end
                S_EMIT_WAIT: begin
                    if (m_tready) begin
                        m_valid_reg <= 1'b0;
                        if (m_last_reg) begin
                            elem_cnt_reg <= '0;
                            if (CNT_CMP_W'(vi_reg) + 1'b1 >= cnt_eff) begin
                                vec_cnt_reg <= '0;
                                vbase_reg   <= '0;
                            end else begin
                                vec_cnt_reg <= vi_reg + 1'b1;
                                vbase_reg   <= BA_W'(vbase_reg + MAX_LENGTH);
                            end
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result beat is pending");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("block not ready after final beat of a vector");

    a_sqrt_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SQRT) |-> $onehot(sq_bit_reg))
        else $error("square-root trial bit lost");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV_IT) |-> (rem_reg < nrm_reg))
        else $error("divider remainder not below norm");

    a_emit_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (state_reg == S_EMIT_WAIT))
        else $error("result beat outside emit phase");

endmodule

// ===== verif/tb_gram_schmidt_orthonormalizer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gram_schmidt_orthonormalizer_core
// Streams Q16.16 vectors through the orthonormaliser and checks every Q2.30
// output beat, with its indexes, tlast and degenerate flag, against a local
// integer model of the normalise / project-out / renormalise sequence.
// Directed vectors cover the extremes, zero norm, clamped register values
// and register changes part way through a vector or a set. Random phases
// follow, under several lengths and set sizes, with random gaps on both
// sides of the block in all phases but the second.
// ----------------------------------------------------------------------------
module tb_gram_schmidt_orthonormalizer_core;
    import gso_pkg::*;

    localparam int  MAX_LEN    = 64;
    localparam int  MAX_VEC    = 16;
    localparam int  PASSES     = 2;
    localparam int  SETTLE     = 40;
    localparam longint LIMIT   = 3000000;
    localparam longint ONE_Q30 = 64'sd1 << 30;

    typedef struct {
        logic [TDATA_W-1:0] tdata;
        logic               last;
        logic               degen;
    } beat_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    // model state
    longint        work_vec [MAX_LEN];
    int            basis_mem[MAX_VEC*MAX_LEN];
    int            elem_cnt;
    int            vec_cnt;
    int            len_reg;
    int            cnt_reg;

    beat_t         pending_beats[$];
    int            errors;
    int            beats_seen;
    int            vectors_sent;
    int            degen_seen;
    longint        cycles;
    bit            idle_on;
    int            ready_hold;

    gram_schmidt_orthonormalizer_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------- arithmetic model ----------------

    function automatic longint unsigned mag64(input longint x);
        return (x < 0) ? longint'(64'd0 - x) : x;
    endfunction

    function automatic longint round_q30(input longint x);
        longint unsigned m;
        m = (mag64(x) + (64'd1 << 29)) >> 30;
        return (x < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint sat_add(input longint a, input longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned align26(input longint unsigned m, input int len);
        if (len > 26) return m >> (len - 26);
        return m << (26 - len);
    endfunction

    // returns 0 on zero norm, vector left untouched
    function automatic bit normalise_work(input int n);
        longint unsigned mx, sum, nrm, b, q;
        int len;
        mx = 0;
        for (int i = 0; i < n; i++)
            if (mag64(work_vec[i]) > mx) mx = mag64(work_vec[i]);
        if (mx == 0) return 1'b0;
        len = 0;
        while (len < 64 && (mx >> len) != 0) len++;
        sum = 0;
        for (int i = 0; i < n; i++) begin
            b   = align26(mag64(work_vec[i]), len);
            sum = sum + b * b;
        end
        nrm = floor_sqrt(sum);
        for (int i = 0; i < n; i++) begin
            b = align26(mag64(work_vec[i]), len);
            q = ((b << 30) + (nrm >> 1)) / nrm;
            if (q > ONE_Q30) q = ONE_Q30;
            work_vec[i] = (work_vec[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic void remove_overlap(input int n, input int j);
        longint acc, ovl;
        acc = 0;
        for (int i = 0; i < n; i++)
            acc = sat_add(acc, work_vec[i] * longint'(basis_mem[j*MAX_LEN+i]));
        ovl = round_q30(acc);
        if (ovl > 2 * ONE_Q30)  ovl = 2 * ONE_Q30;
        if (ovl < -2 * ONE_Q30) ovl = -2 * ONE_Q30;
        for (int i = 0; i < n; i++)
            work_vec[i] = work_vec[i] - round_q30(ovl * longint'(basis_mem[j*MAX_LEN+i]));
    endfunction

    function automatic int eff_len();
        if (len_reg < 1) return 1;
        if (len_reg > MAX_LEN) return MAX_LEN;
        return len_reg;
    endfunction

    function automatic int eff_cnt();
        if (cnt_reg < 1) return 1;
        if (cnt_reg > MAX_VEC) return MAX_VEC;
        return cnt_reg;
    endfunction

    // one accepted element; a completed vector queues its output beats
    function automatic void predict_sample(input logic [SAMPLE_W-1:0] d);
        int     n, vi, cnt;
        bit     degen;
        longint v;
        beat_t  bt;
        cnt = eff_cnt();
        work_vec[elem_cnt] = longint'($signed(d));
        if (elem_cnt + 1 < eff_len()) begin
            elem_cnt++;
            return;
        end
        n     = elem_cnt + 1;
        vi    = vec_cnt;
        degen = !normalise_work(n);
        for (int j = 0; j < vi; j++) begin
            for (int r = 0; r < PASSES; r++) begin
                remove_overlap(n, j);
                if (!normalise_work(n)) degen = 1'b1;
            end
        end
        for (int i = 0; i < n; i++) begin
            v = work_vec[i];
            if (v > 64'sh7FFFFFFF)  v = 64'sh7FFFFFFF;
            if (v < -64'sh80000000) v = -64'sh80000000;
            basis_mem[vi*MAX_LEN+i] = int'(v);
            bt.tdata = {6'd0, 6'(i), 4'(vi), 32'(v)};
            bt.last  = (i + 1 == n);
            bt.degen = degen;
            pending_beats.push_back(bt);
        end
        if (degen) degen_seen++;
        vectors_sent++;
        elem_cnt = 0;
        vec_cnt  = (vi + 1 >= cnt) ? 0 : vi + 1;
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(input string field, input longint got, input longint want);
        if (errors < 30)
            $display("[%0t] mismatch on %s: got %0h, want %0h", $time, field, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata, 0);
            end else begin
                want = pending_beats.pop_front();
                if (m_tdata[31:0] !== want.tdata[31:0])
                    report_mismatch("value", m_tdata[31:0], want.tdata[31:0]);
                if (m_tdata[35:32] !== want.tdata[35:32])
                    report_mismatch("vector_index", m_tdata[35:32], want.tdata[35:32]);
                if (m_tdata[41:36] !== want.tdata[41:36])
                    report_mismatch("element_index", m_tdata[41:36], want.tdata[41:36]);
                if (m_tdata[47:42] !== want.tdata[47:42])
                    report_mismatch("tdata padding", m_tdata[47:42], 0);
                if (m_tlast !== want.last)
                    report_mismatch("tlast", m_tlast, want.last);
                if (m_tuser !== want.degen)
                    report_mismatch("degenerate", m_tuser, want.degen);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout, %0d beats still pending", pending_beats.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------- driving ----------------

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ready for one cycle, then hold it low for a randomly picked gap, which may be zero
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_hold  = 0;
        end else if (ready_hold > 0) begin
            m_tready   <= 1'b0;
            ready_hold  = ready_hold - 1;
        end else begin
            m_tready   <= 1'b1;
            ready_hold  = pick_gap();
        end
    end

    // valid stays high on return so back-to-back beats need no extra edge
    task automatic send_sample(input logic [SAMPLE_W-1:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        predict_sample(d);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= CFG_DATA_W'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == REG_VECTOR_LENGTH) len_reg = val & 8'h7F;
        else                           cnt_reg = val & 8'h1F;
        @(posedge aclk);
    endtask

    function automatic logic [SAMPLE_W-1:0] make_sample(input int mode);
        case (mode)
            0: return '0;
            1: return $urandom();
            2: return SAMPLE_W'($urandom_range(0, 4000) - 2000);
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0001;
                    3: return 32'hFFFF_FFFF;
                    default: return $urandom();
                endcase
            end
        endcase
    endfunction

    task automatic send_vector();
        int mode, r;
        r    = $urandom_range(0, 99);
        mode = (r < 5) ? 0 : (r < 55) ? 1 : (r < 80) ? 2 : 3;
        for (int i = 0; i < eff_len(); i++) send_sample(make_sample(mode));
    endtask

    // bring the set back to vector 0 so a longer length never reads stale basis
    task automatic close_set();
        int keep;
        drain();
        if (vec_cnt != 0) begin
            keep = cnt_reg;
            write_reg(REG_VECTOR_COUNT, 1);
            send_vector();
            drain();
            write_reg(REG_VECTOR_COUNT, keep);
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_extremes();
        write_reg(REG_VECTOR_LENGTH, 2);
        write_reg(REG_VECTOR_COUNT, 16);
        send_sample(32'h7FFF_FFFF); send_sample(32'h8000_0000);
        send_sample(32'h0000_0000); send_sample(32'h0000_0000);   // zero norm
        send_sample(32'h0000_0001); send_sample(32'hFFFF_FFFF);
        send_sample(32'h8000_0000); send_sample(32'h8000_0000);   // orthogonal to an earlier one
        drain();
    endtask

    task automatic test_clamped_registers();
        close_set();
        write_reg(REG_VECTOR_LENGTH, 0);     // behaves as one element
        write_reg(REG_VECTOR_COUNT, 0);      // behaves as a one-vector set
        send_sample(32'h0001_0000);
        send_sample(32'hFFFF_0000);
        drain();
    endtask

    task automatic test_length_cut_mid_vector();
        close_set();
        write_reg(REG_VECTOR_COUNT, 1);
        write_reg(REG_VECTOR_LENGTH, 8);
        for (int i = 0; i < 5; i++) send_sample(make_sample(1));
        drain();
        // shorter than what is already held: the next beat closes the vector
        write_reg(REG_VECTOR_LENGTH, 3);
        send_sample(make_sample(2));
        drain();
    endtask

    task automatic test_count_cut_mid_set();
        close_set();
        write_reg(REG_VECTOR_LENGTH, 2);
        write_reg(REG_VECTOR_COUNT, 16);
        for (int v = 0; v < 3; v++) send_vector();
        drain();
        write_reg(REG_VECTOR_COUNT, 2);      // vector 3 ends the set
        send_vector();
        send_vector();
        drain();
    endtask

    task automatic test_random_phases();
        int lens[5]  = '{4, 8, 127, 1, 3};
        int cnts[5]  = '{31, 5, 2, 16, 7};
        int items[5] = '{64, 80, 128, 24, 48};
        int sent;
        for (int p = 0; p < 5; p++) begin
            close_set();
            idle_on = (p != 1);
            write_reg(REG_VECTOR_LENGTH, lens[p]);
            write_reg(REG_VECTOR_COUNT, cnts[p]);
            sent = 0;
            while (sent < items[p]) begin
                send_vector();
                sent += eff_len();
                if ($urandom_range(0, 9) == 0) drain();
            end
        end
        idle_on = 1'b1;
        drain();
    endtask

    initial begin
        errors       = 0;
        beats_seen   = 0;
        vectors_sent = 0;
        degen_seen   = 0;
        cycles       = 0;
        idle_on      = 1'b1;
        elem_cnt     = 0;
        vec_cnt      = 0;
        len_reg      = 64;
        cnt_reg      = 16;
        foreach (basis_mem[i]) basis_mem[i] = 0;
        foreach (work_vec[i])  work_vec[i]  = 0;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_clamped_registers();
        test_length_cut_mid_vector();
        test_count_cut_mid_set();
        test_random_phases();

        $display("covered %0d vectors (%0d with zero norm), %0d output beats checked",
                 vectors_sent, degen_seen, beats_seen);
        $display("lengths 0..127 and set sizes 0..31 used, with mid-vector and mid-set changes");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== gram_schmidt_orthonormalizer_core.f =====
hw/rtl/gso_pkg.sv
hw/rtl/gso_ram.sv
hw/rtl/gram_schmidt_orthonormalizer_core.sv
verif/tb_gram_schmidt_orthonormalizer_core.sv
